// ===== sv/indexed_min_priority_queue_macros.svh =====
// Assertion macros used by the priority queue datapath.
`ifndef INDEXED_MIN_PRIORITY_QUEUE_MACROS_SVH
`define INDEXED_MIN_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IMPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/impq_pkg.sv =====
// Types and codes shared by the priority queue controller and datapath.
`default_nettype none

package impq_pkg;

    // Operation codes carried on the mode port
    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_EXTRACT  = 2'd1,
        MODE_DECREASE = 2'd2,
        MODE_DELETE   = 2'd3
    } impq_mode_t;

    // Result status codes
    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_EMPTY      = 3'd1,
        STS_LARGER     = 3'd2,
        STS_FULL       = 3'd3,
        STS_BAD_HANDLE = 3'd4
    } impq_status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SCAN,
        S_TAIL,
        S_DONE
    } impq_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_wr;   // write an empty entry at the sweep address
        logic load;       // capture the incoming item
        logic rd_handle;  // read the addressed slot
        logic exec;       // apply the operation, restart the sweep
        logic scan_step;  // read the next slot of the sweep
        logic commit;     // latch minimum and first free slot
    } impq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic idx_last;   // sweep address is at the last slot
    } impq_stat_t;

endpackage

`default_nettype wire

// ===== sv/indexed_min_priority_queue.sv =====
// Top level of the handle-addressed minimum priority queue.
//
//   channel   direction   handshake          payload
//   command   in          start & !busy      mode, key_in, handle_in
//   result    out         done (one cycle)   status, handle_out, key_out, min_key,
//                                            queue_empty, entry_count
//
// Each item passes from acceptance through the READ, EXEC, SCAN and TAIL states to the
// done strobe; busy drops the cycle after done, and no new item is accepted before
// then. The run is set by the sweep that reads one slot per cycle from the single-read
// key store to find the new minimum and the lowest free slot. After reset a clearing
// pass empties the store while busy is high. The receiver cannot stall; each result is
// shown for the one cycle that done is high.
`default_nettype none

module indexed_min_priority_queue import impq_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  mode,
    input  wire logic signed [31:0] key_in,
    input  wire logic        [5:0]  handle_in,
    output logic                    done,
    output logic             [2:0]  status,
    output logic             [5:0]  handle_out,
    output logic signed      [31:0] key_out,
    output logic signed      [31:0] min_key,
    output logic                    queue_empty,
    output logic             [6:0]  entry_count
);

    impq_cmd_t  cmd;
    impq_stat_t stat;

    // Sequencer
    impq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Store and operation datapath
    impq_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .key_in      (key_in),
        .handle_in   (handle_in),
        .status      (status),
        .handle_out  (handle_out),
        .key_out     (key_out),
        .min_key     (min_key),
        .queue_empty (queue_empty),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire

// ===== sv/impq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module impq_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/impq_ctrl.sv =====
// Controller state machine for the priority queue: sequences clear, lookup, update and sweep.
`default_nettype none

module impq_ctrl import impq_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire impq_stat_t stat,
    output impq_cmd_t       cmd,
    output logic            busy,
    output logic            done
);

    impq_state_t state_reg;
    impq_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_handle = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

`default_nettype wire

// ===== sv/impq_dp.sv =====
// Datapath for the priority queue: key store, operation unit and minimum/free-slot sweep.
`default_nettype none
`include "indexed_min_priority_queue_macros.svh"

module impq_dp import impq_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire impq_cmd_t          cmd,
    output impq_stat_t              stat,
    input  wire logic        [1:0]  mode,
    input  wire logic signed [31:0] key_in,
    input  wire logic        [5:0]  handle_in,
    output logic             [2:0]  status,
    output logic             [5:0]  handle_out,
    output logic signed      [31:0] key_out,
    output logic signed      [31:0] min_key,
    output logic                    queue_empty,
    output logic             [6:0]  entry_count
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = KEY_BITS + 1;

    // Captured item
    impq_mode_t                  op_reg;
    logic signed [KEY_BITS-1:0]  key_reg;
    logic        [5:0]           hnd_reg;

    // Queue bookkeeping
    logic        [CNT_W-1:0]     count_reg, count_next;
    logic        [IDX_W-1:0]     min_slot_reg;
    logic signed [KEY_BITS-1:0]  min_key_reg;
    logic        [IDX_W-1:0]     free_slot_reg;

    // Sweep
    logic        [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                        scan_vld_reg;
    logic        [IDX_W-1:0]     scan_slot_reg;
    logic                        found_reg, found_next;
    logic signed [KEY_BITS-1:0]  best_key_reg, best_key_next;
    logic        [IDX_W-1:0]     best_slot_reg, best_slot_next;
    logic                        free_found_reg, free_found_next;
    logic        [IDX_W-1:0]     first_free_reg, first_free_next;

    // Result
    impq_status_t                status_reg, status_next;
    logic        [5:0]           hout_reg, hout_next;
    logic signed [KEY_BITS-1:0]  kout_reg, kout_next;

    // RAM port
    logic                        ram_we;
    logic        [IDX_W-1:0]     ram_waddr;
    logic        [WORD_W-1:0]    ram_wdata;
    logic        [IDX_W-1:0]     ram_raddr;
    logic        [WORD_W-1:0]    ram_rdata;

    logic                        ent_valid;
    logic signed [KEY_BITS-1:0]  ent_key;
    logic                        hnd_ok;

    // Key store: valid bit on top of the key
    impq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = cmd.rd_handle ? IDX_W'(hnd_reg) : scan_idx_reg;
    assign ent_valid = ram_rdata[KEY_BITS];
    assign ent_key   = $signed(ram_rdata[KEY_BITS-1:0]);
    assign hnd_ok    = (int'(hnd_reg) < CAPACITY) && ent_valid;

    assign stat.idx_last = (scan_idx_reg == IDX_W'(CAPACITY - 1));

    // Operation unit: store update and result fields
    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = scan_idx_reg;
        ram_wdata   = '0;
        count_next  = count_reg;
        status_next = status_reg;
        hout_next   = hout_reg;
        kout_next   = kout_reg;
        if (cmd.clear_wr)
        begin
            ram_we = 1'b1;
        end
        if (cmd.exec)
        begin
            status_next = STS_OK;
            hout_next   = '0;
            kout_next   = '0;
            unique case (op_reg)
                MODE_INSERT:
                begin
                    if (count_reg >= CNT_W'(CAPACITY))
                    begin
                        status_next = STS_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = free_slot_reg;
                        ram_wdata  = {1'b1, key_reg};
                        count_next = count_reg + CNT_W'(1);
                        hout_next  = 6'(free_slot_reg);
                    end
                end
                MODE_EXTRACT:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STS_EMPTY;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = min_slot_reg;
                        ram_wdata  = {1'b0, min_key_reg};
                        count_next = count_reg - CNT_W'(1);
                        hout_next  = 6'(min_slot_reg);
                        kout_next  = min_key_reg;
                    end
                end
                MODE_DECREASE:
                begin
                    if (!hnd_ok)
                    begin
                        status_next = STS_BAD_HANDLE;
                    end
                    else if (key_reg > ent_key)
                    begin
                        status_next = STS_LARGER;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = IDX_W'(hnd_reg);
                        ram_wdata = {1'b1, key_reg};
                        hout_next = hnd_reg;
                    end
                end
                MODE_DELETE:
                begin
                    if (!hnd_ok)
                    begin
                        status_next = STS_BAD_HANDLE;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = IDX_W'(hnd_reg);
                        ram_wdata  = {1'b0, ent_key};
                        count_next = count_reg - CNT_W'(1);
                        hout_next  = hnd_reg;
                        kout_next  = ent_key;
                    end
                end
                default:
                begin
                    status_next = STS_OK;
                end
            endcase
        end
    end

    // Sweep: one slot per cycle, lowest slot wins ties
    always_comb
    begin
        scan_idx_next   = scan_idx_reg;
        found_next      = found_reg;
        best_key_next   = best_key_reg;
        best_slot_next  = best_slot_reg;
        free_found_next = free_found_reg;
        first_free_next = first_free_reg;
        if (cmd.clear_wr || cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end
        if (cmd.exec)
        begin
            scan_idx_next   = '0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
        end
        else if (scan_vld_reg)
        begin
            if (ent_valid)
            begin
                if (!found_reg || (ent_key < best_key_reg))
                begin
                    found_next     = 1'b1;
                    best_key_next  = ent_key;
                    best_slot_next = scan_slot_reg;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                first_free_next = scan_slot_reg;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            min_slot_reg   <= '0;
            free_slot_reg  <= '0;
            scan_idx_reg   <= '0;
            scan_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            scan_vld_reg   <= cmd.scan_step;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            if (cmd.commit)
            begin
                min_slot_reg  <= best_slot_next;
                free_slot_reg <= first_free_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= impq_mode_t'(mode);
            key_reg <= KEY_BITS'(key_in);
            hnd_reg <= handle_in;
        end
        if (cmd.commit)
        begin
            min_key_reg <= best_key_next;
        end
        scan_slot_reg  <= scan_idx_reg;
        best_key_reg   <= best_key_next;
        best_slot_reg  <= best_slot_next;
        first_free_reg <= first_free_next;
        status_reg     <= status_next;
        hout_reg       <= hout_next;
        kout_reg       <= kout_next;
    end

    // Result ports
    assign status      = status_reg;
    assign handle_out  = hout_reg;
    assign key_out     = 32'(kout_reg);
    assign min_key     = (count_reg == '0) ? '0 : 32'(min_key_reg);
    assign queue_empty = (count_reg == '0);
    assign entry_count = 7'(count_reg);

    // Checks
    `IMPQ_ASSERT_NEXT(a_insert_count, cmd.exec && (op_reg == MODE_INSERT) && (count_reg < CNT_W'(CAPACITY)), count_reg == $past(count_reg) + CNT_W'(1), "insert did not raise the count")
    `IMPQ_ASSERT_SAME(a_commit_found, cmd.commit && (count_reg != '0), found_next, "sweep found no minimum in a nonempty queue")
    `IMPQ_ASSERT_NEXT(a_exec_restart, cmd.exec, !found_reg && !free_found_reg && (scan_idx_reg == '0), "sweep not restarted after update")

endmodule

`default_nettype wire
